@@ design/ising_heat_bath_site_update_macros.svh @@
// assertion macros shared by the site update block
`ifndef ISING_HEAT_BATH_SITE_UPDATE_MACROS_SVH
`define ISING_HEAT_BATH_SITE_UPDATE_MACROS_SVH

// consequence must hold in the same cycle as the antecedent
`define IHB_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("site update check failed");

// consequence must hold in the cycle after the antecedent
`define IHB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("site update check failed");

`endif

@@ design/ihb_pkg.sv @@
`default_nettype none

package ihb_pkg;

   // coordinate width that covers the largest supported grid side and its size
   localparam int CW = 11;

   // action codes
   localparam logic [1:0] ACT_UPDATE     = 2'd0;
   localparam logic [1:0] ACT_FORCE_UP   = 2'd1;
   localparam logic [1:0] ACT_FORCE_DOWN = 2'd2;
   localparam logic [1:0] ACT_NONE       = 2'd3;

   // boundary modes
   localparam logic [1:0] BND_FIXED_UP   = 2'd1;
   localparam logic [1:0] BND_FIXED_DOWN = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_INV_TEMP = 2'd0;
   localparam logic [1:0] CSR_FIELD    = 2'd1;
   localparam logic [1:0] CSR_COUPLING = 2'd2;
   localparam logic [1:0] CSR_BOUNDARY = 2'd3;

   // register reset values
   localparam logic [11:0] INV_TEMP_RESET = 12'd256;
   localparam logic [11:0] FIELD_RESET    = 12'd0;
   localparam logic [11:0] COUPLING_RESET = 12'd256;

   // which site of the neighborhood is read
   typedef enum logic [2:0] {
      NB_CENTER,
      NB_LEFT,
      NB_RIGHT,
      NB_UP,
      NB_DOWN
   } nbr_sel_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_ACC,
      ST_MUL1,
      ST_MUL2,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic        clear;
      logic        load;
      logic        rd_issue;
      nbr_sel_type rd_sel;
      logic        mul1;
      logic        mul2;
      logic        finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_last;
      logic out_free;
   } sts_type;

   typedef logic [15:0] accept_table_type [256];

   // shift-subtract long division, used only while building the table
   function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // truncating Q40 product split in two halves
   function automatic logic [63:0] mul_q40(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] hi;
      logic [63:0] lo;
      hi = a * (b >> 20);
      lo = (a * (b & 64'hFFFFF)) >> 20;
      return (hi + lo) >> 20;
   endfunction

   // acceptance probability in units of 1/65536, indexed by x in Q4.4 plus 128
   function automatic accept_table_type build_accept_table();
      accept_table_type tbl;
      logic [63:0] pw [129];
      logic [63:0] term;
      logic [63:0] base;
      logic [63:0] u;
      logic [63:0] den;
      logic [63:0] p;
      int          xq;
      term = 64'd1 << 40;
      base = 64'd1 << 40;
      // exp(-1/16) as a series
      for (int n = 1; n <= 14; n++) begin
         term = long_div(term, 64'(16 * n));
         if (n % 2 == 1) begin
            base = base - term;
         end else begin
            base = base + term;
         end
      end
      pw[0] = 64'd1 << 40;
      for (int k = 1; k <= 128; k++) begin
         pw[k] = mul_q40(pw[k - 1], base);
      end
      for (int k = 0; k < 256; k++) begin
         xq = k - 128;
         u = pw[(xq < 0) ? -xq : xq];
         den = (64'd1 << 40) + u;
         if (xq >= 0) begin
            p = long_div(64'd1 << 56, den);
         end else begin
            p = long_div(u << 16, den);
         end
         if (p > 64'd65535) begin
            p = 64'd65535;
         end
         tbl[k] = p[15:0];
      end
      return tbl;
   endfunction

   localparam accept_table_type ACCEPT_TABLE = build_accept_table();

endpackage

`default_nettype wire

@@ design/ihb_ctrl.sv @@
`default_nettype none

module ihb_ctrl (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_tvalid,
   output logic             req_tready,
   input  ihb_pkg::sts_type sts,
   output ihb_pkg::cmd_type cmd
);
   import ihb_pkg::*;

   state_type   state_ff;
   state_type   state_in;
   nbr_sel_type rd_sel_ff;
   nbr_sel_type rd_sel_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (sts.clr_last) state_in = ST_IDLE;
         ST_IDLE:   if (req_tvalid) state_in = ST_READ;
         ST_READ:   if (rd_sel_ff == NB_DOWN) state_in = ST_ACC;
         ST_ACC:    state_in = ST_MUL1;
         ST_MUL1:   state_in = ST_MUL2;
         ST_MUL2:   state_in = ST_FINISH;
         ST_FINISH: if (sts.out_free) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // neighborhood read pointer
   always_comb begin
      rd_sel_in = NB_CENTER;
      if (state_ff == ST_READ && rd_sel_ff != NB_DOWN) begin
         rd_sel_in = nbr_sel_type'(rd_sel_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         rd_sel_ff <= NB_CENTER;
      end else begin
         state_ff  <= state_in;
         rd_sel_ff <= rd_sel_in;
      end
   end

   // commands
   always_comb begin
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.rd_sel   = rd_sel_ff;
      unique case (state_ff)
         ST_CLEAR:  cmd.clear = 1'b1;
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_READ:   cmd.rd_issue = 1'b1;
         ST_ACC:    ;
         ST_MUL1:   cmd.mul1 = 1'b1;
         ST_MUL2:   cmd.mul2 = 1'b1;
         ST_FINISH: cmd.finish = sts.out_free;
         default:   ;
      endcase
   end

endmodule

`default_nettype wire

@@ design/ihb_datapath.sv @@
`default_nettype none

module ihb_datapath #(
   parameter int GRID_WIDTH  = 64,
   parameter int GRID_HEIGHT = 64
) (
   input  wire              clock,
   input  wire              reset,
   input  ihb_pkg::cmd_type cmd,
   output ihb_pkg::sts_type sts,
   input  wire              csr_write,
   input  wire  [1:0]       csr_index,
   input  wire  [11:0]      csr_data,
   input  wire  [31:0]      req_tdata,
   output logic             rsp_tvalid,
   input  wire              rsp_tready,
   output logic [7:0]       rsp_tdata
);
   import ihb_pkg::*;

   localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
   localparam int AW = $clog2(DEPTH);
   localparam logic [CW-1:0] GW = CW'(GRID_WIDTH);
   localparam logic [CW-1:0] GH = CW'(GRID_HEIGHT);

   // configuration
   logic [11:0] beta_ff;
   logic [11:0] field_h_ff;
   logic [11:0] coupling_ff;
   logic [1:0]  mode_ff;

   // item registers
   logic [1:0]  action_ff;
   logic [5:0]  site_x_ff;
   logic [5:0]  site_y_ff;
   logic [15:0] draw_ff;

   logic               spin_mem_ff [DEPTH];
   logic               rd_data_ff;
   logic [AW-1:0]      clr_ff;
   logic               pend_valid_ff;
   logic               pend_center_ff;
   logic               pend_exists_ff;
   logic               pend_forced_ff;
   logic signed [3:0]  sum_ff;
   logic               center_ff;
   logic signed [15:0] lfield_ff;
   logic signed [28:0] bf_ff;
   logic               rsp_valid_ff;
   logic [5:0]         rsp_data_ff;

   logic [CW-1:0]      x_e;
   logic [CW-1:0]      y_e;
   logic               in_grid;
   logic               fixed;
   logic               fixed_up;
   logic [CW-1:0]      nx;
   logic [CW-1:0]      ny;
   logic               exists;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      center_addr;
   logic               spin_rd;
   logic signed [15:0] coup_ext;
   logic signed [15:0] sum_ext;
   logic signed [15:0] lfield_in;
   logic signed [28:0] beta_ext;
   logic signed [28:0] lfield_ext;
   logic signed [17:0] xq;
   logic [7:0]         tbl_idx;
   logic               heat_up;
   logic               new_spin;
   logic               do_write;
   logic               out_spin;
   logic               mem_wr;
   logic [AW-1:0]      mem_wr_addr;
   logic               mem_wr_bit;

   function automatic logic on_edge(input logic [CW-1:0] cx, input logic [CW-1:0] cy);
      return cx == '0 || cy == '0 || cx == GW - 1'b1 || cy == GH - 1'b1;
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff     <= INV_TEMP_RESET;
         field_h_ff  <= FIELD_RESET;
         coupling_ff <= COUPLING_RESET;
         mode_ff     <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_INV_TEMP: beta_ff     <= csr_data;
            CSR_FIELD:    field_h_ff  <= csr_data;
            CSR_COUPLING: coupling_ff <= csr_data;
            CSR_BOUNDARY: mode_ff     <= csr_data[1:0];
            default:      ;
         endcase
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_tdata[1:0];
         site_x_ff <= req_tdata[7:2];
         site_y_ff <= req_tdata[13:8];
         draw_ff   <= req_tdata[29:14];
      end
   end

   // site geometry
   assign x_e         = CW'(site_x_ff);
   assign y_e         = CW'(site_y_ff);
   assign in_grid     = (x_e < GW) && (y_e < GH);
   assign fixed       = (mode_ff == BND_FIXED_UP) || (mode_ff == BND_FIXED_DOWN);
   assign fixed_up    = (mode_ff == BND_FIXED_UP);
   assign center_addr = AW'(32'(y_e) * GRID_WIDTH + 32'(x_e));

   // neighbor coordinates for the current read
   always_comb begin
      nx     = x_e;
      ny     = y_e;
      exists = in_grid;
      case (cmd.rd_sel)
         NB_LEFT: begin
            nx     = x_e - 1'b1;
            exists = in_grid && (x_e != '0);
         end
         NB_RIGHT: begin
            nx     = x_e + 1'b1;
            exists = in_grid && (x_e + 1'b1 < GW);
         end
         NB_UP: begin
            ny     = y_e - 1'b1;
            exists = in_grid && (y_e != '0);
         end
         NB_DOWN: begin
            ny     = y_e + 1'b1;
            exists = in_grid && (y_e + 1'b1 < GH);
         end
         default: ;
      endcase
   end

   assign rd_addr = exists ? AW'(32'(ny) * GRID_WIDTH + 32'(nx)) : '0;

   // clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   assign sts.clr_last = (clr_ff == AW'(DEPTH - 1));

   // spin memory, one read and one write port
   always_comb begin
      mem_wr      = 1'b0;
      mem_wr_addr = center_addr;
      mem_wr_bit  = new_spin;
      if (cmd.clear) begin
         mem_wr      = 1'b1;
         mem_wr_addr = clr_ff;
         mem_wr_bit  = 1'b0;
      end else if (cmd.finish && do_write) begin
         mem_wr = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         spin_mem_ff[mem_wr_addr] <= mem_wr_bit;
      end
      rd_data_ff <= spin_mem_ff[rd_addr];
   end

   // read in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= cmd.rd_issue;
      end
   end

   always_ff @(posedge clock) begin
      pend_center_ff <= (cmd.rd_sel == NB_CENTER);
      pend_exists_ff <= exists;
      pend_forced_ff <= fixed && on_edge(nx, ny);
   end

   // neighbor accumulation
   assign spin_rd = pend_forced_ff ? fixed_up : rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sum_ff <= '0;
      end else if (pend_valid_ff) begin
         if (pend_center_ff) begin
            center_ff <= spin_rd;
         end else if (pend_exists_ff) begin
            sum_ff <= spin_rd ? sum_ff + 4'sd1 : sum_ff - 4'sd1;
         end
      end
   end

   // local field h + J*sum
   assign coup_ext  = {{4{coupling_ff[11]}}, coupling_ff};
   assign sum_ext   = {{12{sum_ff[3]}}, sum_ff};
   assign lfield_in = coup_ext * sum_ext + {{4{field_h_ff[11]}}, field_h_ff};

   // beta times local field
   assign beta_ext   = {17'd0, beta_ff};
   assign lfield_ext = {{13{lfield_ff[15]}}, lfield_ff};

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         lfield_ff <= lfield_in;
      end
      if (cmd.mul2) begin
         bf_ff <= beta_ext * lfield_ext;
      end
   end

   // x = 2*beta*L in Q4.4 with clamping, then table lookup
   assign xq = bf_ff[28:11];

   always_comb begin
      if (xq < -18'sd128) begin
         tbl_idx = 8'd0;
      end else if (xq > 18'sd127) begin
         tbl_idx = 8'd255;
      end else begin
         tbl_idx = {~xq[7], xq[6:0]};
      end
   end

   assign heat_up = draw_ff < ACCEPT_TABLE[tbl_idx];

   // new spin and result fields
   always_comb begin
      case (action_ff)
         ACT_UPDATE:   new_spin = heat_up;
         ACT_FORCE_UP: new_spin = 1'b1;
         default:      new_spin = 1'b0;
      endcase
   end

   assign do_write = in_grid && !(fixed && on_edge(x_e, y_e)) && (action_ff != ACT_NONE);

   always_comb begin
      if (!in_grid) begin
         out_spin = 1'b0;
      end else if (do_write) begin
         out_spin = new_spin;
      end else begin
         out_spin = center_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff <= {(in_grid ? sum_ff : 4'sd0), do_write, out_spin};
      end
   end

   assign sts.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {2'b00, rsp_data_ff};

endmodule

`default_nettype wire

@@ design/ising_heat_bath_site_update.sv @@
// channel   dir  ports                                    payload
// req       in   req_tvalid req_tready req_tdata[31:0]     one site action
// rsp       out  rsp_tvalid rsp_tready rsp_tdata[7:0]      resulting spin and neighbor sum
// csr       in   csr_valid csr_ready csr_index csr_data    register write, always ready
//
// after an item's transfer come one read a cycle for the site and its four neighbors on
// the single read port of the spin memory, an accumulate step, two multiply stages and a
// lookup and write-back step, and then rsp_tvalid rises; a new item is taken only once the
// last one has finished, in the idle accept step.
// after reset a clearing pass writes every site down; req_tready stays low until it ends.
// a result waiting on rsp holds the block in its last step; the next item is taken
// in the cycle after that result has been handed to the output register.
`default_nettype none

`include "ising_heat_bath_site_update_macros.svh"

module ising_heat_bath_site_update #(
   parameter int GRID_WIDTH  = 64,
   parameter int GRID_HEIGHT = 64
) (
   input  wire         clock,
   input  wire         reset,
   // request
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // action[1:0] site_x[7:2] site_y[13:8] random_draw[29:14]
   // response
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // spin_up[0] was_written[1] neighbor_sum[5:2]
   // configuration
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [11:0] csr_data
);
   import ihb_pkg::*;

   cmd_type ctrl_cmd;
   sts_type dp_sts;
   logic signed [3:0] result_sum;

   assign csr_ready = 1'b1;

   // sequencer
   ihb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (dp_sts),
      .cmd        (ctrl_cmd)
   );

   // spin memory and arithmetic
   ihb_datapath #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (ctrl_cmd),
      .sts        (dp_sts),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   assign result_sum = rsp_tdata[5:2];

   // one item at a time
   `IHB_ASSERT_NEXT(a_one_item_in_flight, req_tvalid && req_tready, !req_tready)
   // a finished item always lands in the output register
   `IHB_ASSERT_NEXT(a_finish_shows_result, ctrl_cmd.finish, rsp_tvalid)
   // neighbor sum stays within four neighbors
   `IHB_ASSERT_SAME(a_sum_in_range, rsp_tvalid, (result_sum >= -4'sd4) && (result_sum <= 4'sd4))

endmodule

`default_nettype wire

@@ dv/tb_ising_heat_bath_site_update.sv @@
module tb_ising_heat_bath_site_update;
   import ihb_pkg::*;

   localparam int GRID_W = 64;
   localparam int GRID_H = 64;
   localparam int HOLD_CYCLES = 400;

   // boundary modes without a package name
   localparam logic [1:0] BND_OPEN     = 2'd0;
   localparam logic [1:0] BND_OPEN_ALT = 2'd3;

   // one site action, action in the low bits
   typedef struct packed {
      logic [15:0] draw;
      logic [5:0]  y;
      logic [5:0]  x;
      logic [1:0]  action;
   } site_req_type;

   typedef struct packed {
      logic       spin_up;
      logic       was_written;
      logic [3:0] neighbor_sum;
   } site_rsp_type;

   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_SPARSE,
      RDY_TOGGLE
   } ready_pattern_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;  // action[1:0] site_x[7:2] site_y[13:8] random_draw[29:14]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;       // spin_up[0] was_written[1] neighbor_sum[5:2]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_INV_TEMP;
   logic [11:0] csr_data = '0;

   ising_heat_bath_site_update #(
      .GRID_WIDTH (GRID_W),
      .GRID_HEIGHT(GRID_H)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // mirror of the lattice and the registers
   logic               spin_grid [0:GRID_W*GRID_H-1];
   logic [15:0]        accept_lut [0:255];
   logic [11:0]        cfg_beta = INV_TEMP_RESET;
   logic signed [11:0] cfg_field = FIELD_RESET;
   logic signed [11:0] cfg_coupling = COUPLING_RESET;
   logic [1:0]         cfg_bnd = BND_OPEN;

   site_req_type pending_sites [$];
   site_rsp_type expected_spins [$];
   int           mismatch_count = 0;
   int           hold_req = 0;
   // items taken from the pending queue whose result has not come back
   int           items_open = 0;

   // truncating product of two Q40 values
   function automatic longint unsigned q40_mul(longint unsigned a, longint unsigned b);
      longint unsigned upper;
      longint unsigned lower;
      upper = a * (b >> 20);
      lower = (a * (b & 64'hFFFFF)) >> 20;
      return (upper + lower) >> 20;
   endfunction

   // logistic acceptance in 1/65536 units, index is x in Q4.4 plus 128
   task automatic build_accept_lut;
      longint unsigned term;
      longint unsigned ebase;
      longint unsigned u;
      longint unsigned den;
      longint unsigned q;
      longint unsigned pw [0:128];
      int mag;
      term = 64'd1 << 40;
      ebase = 64'd1 << 40;
      // exp(-1/16) by its series
      for (int n = 1; n <= 14; n++) begin
         term = term / 64'(16 * n);
         if (n % 2 == 1) begin
            ebase = ebase - term;
         end else begin
            ebase = ebase + term;
         end
      end
      pw[0] = 64'd1 << 40;
      for (int k = 1; k <= 128; k++) begin
         pw[k] = q40_mul(pw[k - 1], ebase);
      end
      for (int k = 0; k < 256; k++) begin
         mag = (k < 128) ? 128 - k : k - 128;
         u = pw[mag];
         den = (64'd1 << 40) + u;
         if (k >= 128) begin
            q = (64'd1 << 56) / den;
         end else begin
            q = (u << 16) / den;
         end
         if (q > 64'd65535) begin
            q = 64'd65535;
         end
         accept_lut[k] = q[15:0];
      end
   endtask

   function automatic logic pinned_mode();
      return cfg_bnd == BND_FIXED_UP || cfg_bnd == BND_FIXED_DOWN;
   endfunction

   function automatic logic on_rim(int x, int y);
      return x == 0 || y == 0 || x == GRID_W - 1 || y == GRID_H - 1;
   endfunction

   // spin as seen by the update, rim pinned in the fixed modes
   function automatic logic site_spin(int x, int y);
      if (pinned_mode() && on_rim(x, y)) begin
         return cfg_bnd == BND_FIXED_UP;
      end
      return spin_grid[y * GRID_W + x];
   endfunction

   // one site step on the mirror lattice
   function automatic site_rsp_type heat_bath_predict(site_req_type it);
      site_rsp_type r;
      int        sx;
      int        sy;
      int        nsum;
      logic      spin;
      logic      writable;
      logic      written;
      longint    fld;
      longint    prod;
      longint    xq;
      sx = it.x;
      sy = it.y;
      nsum = 0;
      written = 1'b0;
      if (sx > 0) nsum += site_spin(sx - 1, sy) ? 1 : -1;
      if (sx + 1 < GRID_W) nsum += site_spin(sx + 1, sy) ? 1 : -1;
      if (sy > 0) nsum += site_spin(sx, sy - 1) ? 1 : -1;
      if (sy + 1 < GRID_H) nsum += site_spin(sx, sy + 1) ? 1 : -1;
      writable = !(pinned_mode() && on_rim(sx, sy));
      spin = site_spin(sx, sy);
      if (writable && it.action != ACT_NONE) begin
         if (it.action == ACT_UPDATE) begin
            fld = longint'(cfg_field) + longint'(cfg_coupling) * nsum;
            prod = 2 * longint'(cfg_beta) * fld;
            xq = prod >>> 12;
            if (xq < -128) xq = -128;
            if (xq > 127) xq = 127;
            spin = it.draw < accept_lut[xq + 128];
         end else begin
            spin = it.action == ACT_FORCE_UP;
         end
         spin_grid[sy * GRID_W + sx] = spin;
         written = 1'b1;
      end
      r.spin_up = spin;
      r.was_written = written;
      r.neighbor_sum = 4'(nsum);
      return r;
   endfunction

   // driver: bursts of items from the pending queue with random gaps
   site_req_type launch_item;
   logic      nxt_valid;
   int        burst_left = 0;
   int        gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         nxt_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_spins.insert(expected_spins.size(), heat_bath_predict(launch_item));
            nxt_valid = 1'b0;
         end
         if (!nxt_valid) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
            end else if (pending_sites.size() > 0) begin
               launch_item = pending_sites.pop_front();
               items_open++;
               req_tdata <= {2'b00, launch_item.draw, launch_item.y, launch_item.x,
                             launch_item.action};
               nxt_valid = 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
         req_tvalid <= nxt_valid;
      end
   end

   // receiver: changing ready patterns plus a long hold-off on request
   ready_pattern_type rdy_kind = RDY_ALWAYS;
   int             rdy_left = 0;
   int             hold_left = 0;
   int             hold_seen = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         if (rdy_left == 0) begin
            rdy_left <= $urandom_range(8, 80);
            rdy_kind <= ready_pattern_type'($urandom_range(0, 3));
         end else begin
            rdy_left <= rdy_left - 1;
         end
         case (rdy_kind)
            RDY_ALWAYS: rsp_tready <= 1'b1;
            RDY_COIN:   rsp_tready <= $urandom_range(0, 1);
            RDY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:    rsp_tready <= ~rsp_tready;
         endcase
      end
   end

   task automatic report_mismatch(string what, site_rsp_type want, site_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s: expected spin %0d written %0d sum %0d, got spin %0d written %0d sum %0d",
                  what, want.spin_up, want.was_written, $signed(want.neighbor_sum),
                  got.spin_up, got.was_written, $signed(got.neighbor_sum));
      end
   endtask

   // monitor: compare each result transfer with the oldest prediction
   site_rsp_type seen_rsp;
   site_rsp_type want_rsp;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_rsp.spin_up = rsp_tdata[0];
         seen_rsp.was_written = rsp_tdata[1];
         seen_rsp.neighbor_sum = rsp_tdata[5:2];
         if (expected_spins.size() == 0) begin
            report_mismatch("unexpected result", '0, seen_rsp);
         end else begin
            want_rsp = expected_spins.pop_front();
            items_open--;
            if (seen_rsp != want_rsp) begin
               report_mismatch("result mismatch", want_rsp, seen_rsp);
            end
         end
      end
   end

   // register write, mirror updated at the transfer
   task automatic csr_write(logic [1:0] idx, logic [11:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_INV_TEMP: cfg_beta = val;
         CSR_FIELD:    cfg_field = val;
         CSR_COUPLING: cfg_coupling = val;
         CSR_BOUNDARY: cfg_bnd = val[1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic write_all(logic [11:0] beta, logic [11:0] h, logic [11:0] j, logic [1:0] bnd);
      csr_write(CSR_INV_TEMP, beta);
      csr_write(CSR_FIELD, h);
      csr_write(CSR_COUPLING, j);
      csr_write(CSR_BOUNDARY, {10'd0, bnd});
   endtask

   task automatic queue_site(logic [1:0] act, int x, int y, int draw);
      site_req_type it;
      it.action = act;
      it.x = 6'(x);
      it.y = 6'(y);
      it.draw = 16'(draw);
      pending_sites.insert(pending_sites.size(), it);
   endtask

   task automatic wait_drained;
      while (pending_sites.size() != 0 || items_open != 0)
         @(posedge clock);
   endtask

   // mostly small windows so neighbors have been written, some far sites
   task automatic queue_random_sites(int count);
      int wx;
      int wy;
      int x;
      int y;
      int r;
      int draw;
      logic [1:0] act;
      wx = 0;
      wy = 0;
      for (int n = 0; n < count; n++) begin
         if (n % 25 == 0) begin
            case ($urandom_range(0, 3))
               0: wx = 0;
               1: wx = GRID_W - 6;
               default: wx = $urandom_range(0, GRID_W - 6);
            endcase
            case ($urandom_range(0, 3))
               0: wy = 0;
               1: wy = GRID_H - 6;
               default: wy = $urandom_range(0, GRID_H - 6);
            endcase
         end
         if ($urandom_range(0, 4) == 0) begin
            x = $urandom_range(0, GRID_W - 1);
            y = $urandom_range(0, GRID_H - 1);
         end else begin
            x = wx + $urandom_range(0, 5);
            y = wy + $urandom_range(0, 5);
         end
         r = $urandom_range(0, 99);
         if (r < 60) act = ACT_UPDATE;
         else if (r < 75) act = ACT_FORCE_UP;
         else if (r < 90) act = ACT_FORCE_DOWN;
         else act = ACT_NONE;
         case ($urandom_range(0, 9))
            0: draw = 0;
            1: draw = 65535;
            default: draw = $urandom_range(0, 65535);
         endcase
         queue_site(act, x, y, draw);
      end
   endtask

   // stimulus and end of run
   initial begin
      logic [11:0] beta;
      logic [11:0] h;
      logic [11:0] j;
      for (int i = 0; i < GRID_W * GRID_H; i++) spin_grid[i] = 1'b0;
      build_accept_lut();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings, all down lattice, corners and edges
      queue_site(ACT_UPDATE, 32, 32, 0);
      queue_site(ACT_UPDATE, 32, 32, 65535);
      queue_site(ACT_FORCE_UP, 0, 0, 0);
      queue_site(ACT_FORCE_UP, 63, 63, 65535);
      queue_site(ACT_FORCE_UP, 1, 0, 0);
      queue_site(ACT_UPDATE, 0, 1, 32768);
      queue_site(ACT_NONE, 0, 0, 0);
      queue_site(ACT_FORCE_DOWN, 0, 0, 65535);
      queue_site(ACT_FORCE_UP, 63, 0, 0);
      queue_site(ACT_UPDATE, 62, 0, 32768);
      wait_drained();

      // rim pinned up: rim sites not written, rim neighbors read up
      write_all(12'd4095, 12'd2047, 12'h800, BND_FIXED_UP);
      queue_site(ACT_UPDATE, 0, 5, 0);
      queue_site(ACT_FORCE_DOWN, 63, 63, 0);
      queue_site(ACT_UPDATE, 1, 1, 65535);
      queue_site(ACT_FORCE_DOWN, 1, 1, 0);
      queue_site(ACT_NONE, 0, 63, 65535);
      wait_drained();

      // rim pinned down, zero beta puts p at one half
      write_all(12'd0, 12'h800, 12'd2047, BND_FIXED_DOWN);
      queue_site(ACT_UPDATE, 2, 2, 32767);
      queue_site(ACT_UPDATE, 2, 2, 32768);
      queue_site(ACT_FORCE_UP, 0, 32, 0);
      queue_site(ACT_UPDATE, 1, 62, 100);
      wait_drained();

      // mode three acts as variable, stored rim values show again
      write_all(12'd4095, 12'h800, 12'd0, BND_OPEN_ALT);
      queue_site(ACT_UPDATE, 0, 0, 0);
      queue_site(ACT_UPDATE, 63, 63, 0);
      queue_site(ACT_FORCE_DOWN, 63, 63, 0);
      queue_site(ACT_UPDATE, 31, 31, 65535);
      wait_drained();

      // random phases, each under fresh settings
      for (int ph = 0; ph < 8; ph++) begin
         if (ph % 4 == 0) begin
            beta = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
            h = $urandom_range(0, 1) ? 12'd2047 : 12'h800;
            j = $urandom_range(0, 1) ? 12'd2047 : 12'h800;
         end else begin
            beta = $urandom_range(0, 700);
            h = 12'($urandom_range(0, 600) - 300);
            j = 12'($urandom_range(0, 1400) - 700);
         end
         write_all(beta, h, j, 2'($urandom_range(0, 3)));
         if (ph == 2) begin
            hold_req = hold_req + 1;
         end
         queue_random_sites(200);
         wait_drained();
      end

      repeat (24) @(posedge clock);
      if (mismatch_count == 0 && expected_spins.size() == 0) begin
         $display("tb_ising_heat_bath_site_update OK");
      end else begin
         $display("tb_ising_heat_bath_site_update NOT OK");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("tb_ising_heat_bath_site_update NOT OK");
      $finish;
   end

endmodule
